[rtl/core/kvi_pkg.sv]
`timescale 1ns / 1ps
// kvi_pkg: shared types and constants of the keyframe vector interpolator.
// No dependencies.
package kvi_pkg;

  localparam int unsigned DefMaxKeys = 64;
  localparam int unsigned FracW      = 16;
  localparam int unsigned FactW      = FracW + 1;   // 0..65536
  localparam int unsigned SegOutW    = 6;
  localparam int unsigned CfgW       = 7;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic [31:0] tk;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } key_t;

  // sample transaction travelling along the key cells
  typedef struct packed {
    logic        valid;
    logic        done;   // segment settled
    logic        full;   // past the last key, factor is 1.0
    logic [31:0] ts;     // sample time
    key_t        prev;   // key of the previous cell
    key_t        s;      // segment start
    key_t        e;      // segment end
  } tok_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAIN,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

endpackage

[rtl/core/keyframe_vector_interpolator.sv]
`timescale 1ns / 1ps
// keyframe_vector_interpolator: keyframe track sampler, top level.
// Depends on kvi_pkg, kvi_cell, kvi_div.
//
// Keys live in a row of MaxKeys cells, one key per cell. A write transaction
// (func = 0) loads one cell in its accept cycle and gives no result; a key
// index at or above MaxKeys is dropped. A sample transaction (func = 1)
// walks the row one cell per cycle, the first cell whose time exceeds the
// sample time fixing the segment; past the last key the last key is held.
// The factor (t - t0) / (t1 - t0) in Q1.16 then comes from a bit-serial
// divider, which skips its bit loop when clamped or for a zero-length segment,
// and one shared 33x18 multiplier forms x, y and z in turn. A sample is
// accepted only when the previous one is finished.
// key_count 0 acts as 1, values above MaxKeys act as MaxKeys. Keys read
// before they are written give undefined results. No clearing pass.
module keyframe_vector_interpolator import kvi_pkg::*; #(
  parameter int unsigned MaxKeys = DefMaxKeys,
  localparam int unsigned IdxW   = $clog2(MaxKeys),
  localparam int unsigned CntW   = $clog2(MaxKeys + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [5:0]          key_index_i,
  input  logic [31:0]         key_time_i,
  input  logic signed [31:0]  key_x_i,
  input  logic signed [31:0]  key_y_i,
  input  logic signed [31:0]  key_z_i,
  input  logic [31:0]         sample_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic [SegOutW-1:0]  segment_index_o
);

  state_e state_q, state_d;

  logic [CfgW-1:0] key_count_q;
  logic [CntW-1:0] n_q;
  logic [31:0]     cnt32;

  logic in_acc, wr_en, inject;
  logic div_start, mul_run, out_load;

  tok_t            tok  [MaxKeys+1];
  logic [IdxW-1:0] seg  [MaxKeys+1];
  logic [MaxKeys-1:0] tok_vld;
  key_t            wr_key;
  logic            wr_ok;

  key_t            s_q, e_q;
  logic [IdxW-1:0] seg_q;

  logic             div_done;
  logic [FactW-1:0] fact;
  logic [FactW-1:0] fact_q;

  logic [1:0]         mcnt_q;
  logic signed [32:0] dif;
  logic signed [50:0] prod_q;
  logic signed [50:0] prod_rnd;
  logic [31:0]        s_sel, e_sel, s_prev;
  logic [31:0]        res_q [3];

  logic out_valid_q;

  // ---- configuration: key_count, clamped to 1..MaxKeys for the cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cnt32 = 32'(key_count_q);
    if (cnt32 == 0) begin
      n_q = CntW'(1);
    end else if (cnt32 > MaxKeys) begin
      n_q = CntW'(MaxKeys);
    end else begin
      n_q = CntW'(cnt32);
    end
  end

  // ---- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && func_i == FUNC_SAMPLE) begin
          state_d = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        if (tok[MaxKeys].valid) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mcnt_q == 2'd3) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    inject     = in_acc && func_i == FUNC_SAMPLE;
    wr_en      = in_acc && func_i == FUNC_WRITE && wr_ok;
    div_start  = (state_q == ST_CHAIN) && tok[MaxKeys].valid;
    mul_run    = (state_q == ST_MUL);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- key cells
  assign wr_ok  = 32'(key_index_i) < MaxKeys;
  assign wr_key = '{tk: key_time_i, x: key_x_i, y: key_y_i, z: key_z_i};

  assign tok[0] = '{valid: inject, ts: sample_time_i, default: '0};
  assign seg[0] = '0;

  for (genvar k = 0; k < MaxKeys; k++) begin : g_cell
    kvi_cell #(
      .MaxKeys (MaxKeys),
      .Idx     (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .we_i     (wr_en),
      .wr_idx_i (IdxW'(key_index_i)),
      .wr_key_i (wr_key),
      .n_i      (n_q),
      .tok_i    (tok[k]),
      .seg_i    (seg[k]),
      .tok_o    (tok[k+1]),
      .seg_o    (seg[k+1])
    );
    assign tok_vld[k] = tok[k+1].valid;
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      s_q    <= tok[MaxKeys].s;
      e_q    <= tok[MaxKeys].e;
      seg_q  <= seg[MaxKeys];
    end
  end

  // ---- factor
  kvi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .full_i  (tok[MaxKeys].full),
    .ts_i    (tok[MaxKeys].ts),
    .t0_i    (tok[MaxKeys].s.tk),
    .t1_i    (tok[MaxKeys].e.tk),
    .done_o  (div_done),
    .fact_o  (fact)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      fact_q <= fact;
    end
  end

  // ---- blend: mcnt_q selects the component; its product is registered, then added to its start value
  always_comb begin
    unique case (mcnt_q)
      2'd0:    begin s_sel = s_q.x; e_sel = e_q.x; s_prev = s_q.z; end
      2'd1:    begin s_sel = s_q.y; e_sel = e_q.y; s_prev = s_q.x; end
      2'd2:    begin s_sel = s_q.z; e_sel = e_q.z; s_prev = s_q.y; end
      default: begin s_sel = s_q.z; e_sel = e_q.z; s_prev = s_q.z; end
    endcase
    dif      = $signed({e_sel[31], e_sel}) - $signed({s_sel[31], s_sel});
    prod_rnd = (prod_q + 51'sd32768) >>> FracW;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (mul_run) begin
      mcnt_q <= mcnt_q + 2'd1;
    end else begin
      mcnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_run) begin
      prod_q <= 51'(dif * $signed({1'b0, fact_q}));
      if (mcnt_q != 2'd0) begin
        res_q[mcnt_q - 2'd1] <= s_prev + prod_rnd[31:0];
      end
    end
  end

  // ---- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_o         <= res_q[0];
      out_y_o         <= res_q[1];
      out_z_o         <= res_q[2];
      segment_index_o <= SegOutW'(seg_q);
    end
  end

  assign out_valid_o = out_valid_q;

  // ---- checks
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one sample in the key row");

  a_chain_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MaxKeys].valid |-> state_q == ST_CHAIN)
    else $error("sample left the key row outside the search state");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("factor finished outside the divide state");

  a_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MaxKeys].valid |-> tok[MaxKeys].done)
    else $error("sample left the key row without a segment");

endmodule

[rtl/core/kvi_cell.sv]
`timescale 1ns / 1ps
// kvi_cell: one key slot of the track plus one stage of the segment search.
// Depends on kvi_pkg.
module kvi_cell import kvi_pkg::*; #(
  parameter int unsigned MaxKeys = DefMaxKeys,
  parameter int unsigned Idx     = 0,
  localparam int unsigned IdxW   = $clog2(MaxKeys),
  localparam int unsigned CntW   = $clog2(MaxKeys + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  key_t            wr_key_i,
  input  logic [CntW-1:0] n_i,
  input  tok_t            tok_i,
  input  logic [IdxW-1:0] seg_i,
  output tok_t            tok_o,
  output logic [IdxW-1:0] seg_o
);

  key_t            key_q;
  tok_t            tok_d, tok_q;
  logic            valid_q;
  logic [IdxW-1:0] seg_d, seg_q;

  always_ff @(posedge clk_i) begin
    if (we_i && wr_idx_i == IdxW'(Idx)) begin
      key_q <= wr_key_i;
    end
  end

  always_comb begin
    tok_d      = tok_i;
    seg_d      = seg_i;
    tok_d.prev = key_q;
    if (Idx == 0) begin
      tok_d.done = 1'b0;
      tok_d.full = 1'b0;
      seg_d      = '0;
      if (n_i == CntW'(1)) begin
        tok_d.done = 1'b1;
        tok_d.s    = key_q;
        tok_d.e    = key_q;
      end
    end else if (tok_i.valid && !tok_i.done && 32'(n_i) > Idx) begin
      if (tok_i.ts < key_q.tk) begin
        tok_d.done = 1'b1;
        tok_d.s    = tok_i.prev;
        tok_d.e    = key_q;
        seg_d      = IdxW'(Idx - 1);
      end else if (32'(n_i) == Idx + 1) begin
        tok_d.done = 1'b1;
        tok_d.full = 1'b1;
        tok_d.s    = tok_i.prev;
        tok_d.e    = key_q;
        seg_d      = IdxW'(Idx - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    seg_q <= seg_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

  assign seg_o = seg_q;

endmodule

[rtl/core/kvi_div.sv]
`timescale 1ns / 1ps
// kvi_div: interpolation factor, restoring division one quotient bit a cycle.
// Depends on kvi_pkg.
module kvi_div import kvi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             full_i,
  input  logic [31:0]      ts_i,
  input  logic [31:0]      t0_i,
  input  logic [31:0]      t1_i,
  output logic             done_o,
  output logic [FactW-1:0] fact_o
);

  localparam int unsigned StepW = $clog2(FracW + 1);

  logic [31:0]      rem_q, rem_d, den_q, den_d;
  logic [FactW-1:0] fact_q, fact_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [32:0]      rem2;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    fact_d = fact_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem2   = {rem_q, 1'b0};
    if (start_i) begin
      priority if (full_i) begin
        fact_d = FactW'(1) << FracW;
        done_d = 1'b1;
      end else if (t1_i <= t0_i || ts_i <= t0_i) begin
        fact_d = '0;
        done_d = 1'b1;
      end else begin
        rem_d  = ts_i - t0_i;       // below den, so quotient fits FracW bits
        den_d  = t1_i - t0_i;
        fact_d = '0;
        step_d = StepW'(FracW);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d  = 32'(rem2 - {1'b0, den_q});
        fact_d = {fact_q[FactW-2:0], 1'b1};
      end else begin
        rem_d  = rem2[31:0];
        fact_d = {fact_q[FactW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    fact_q <= fact_d;
  end

  assign done_o = done_q;
  assign fact_o = fact_q;

endmodule
